// ----- sv/plce_pkg.sv -----
package plce_pkg;

  localparam int DEPTH   = 256;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int POS_W   = 16;
  localparam int ACT_W   = 2;
  localparam int STAT_W  = 2;

  localparam logic [ACT_W-1:0] ACT_GET    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DIV    = 8'b0000_0010,
    S_INS_RD = 8'b0000_0100,
    S_INS_FH = 8'b0000_1000,
    S_WALK   = 8'b0001_0000,
    S_STEP   = 8'b0010_0000,
    S_WR1    = 8'b0100_0000,
    S_WR2    = 8'b1000_0000
  } state_e;

endpackage

// ----- sv/plce_div.sv -----
module plce_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [plce_pkg::POS_W-1:0]  dividend_i,
  input  logic [plce_pkg::CNT_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [plce_pkg::IDX_W-1:0]  rem_o
);
  import plce_pkg::*;

  localparam int ITER_W = $clog2(POS_W + 1);

  logic              busy_q, busy_d, done_q, done_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [POS_W-1:0]  quo_q, quo_d;
  logic [CNT_W:0]    rem_q, rem_d;
  logic [CNT_W:0]    trial;

  assign trial = {rem_q[CNT_W-1:0], quo_q[POS_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = ITER_W'(POS_W);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d  = (trial >= {1'b0, divisor_i}) ? trial - {1'b0, divisor_i} : trial;
      quo_d  = {quo_q[POS_W-2:0], 1'b0};
      iter_d = iter_q - ITER_W'(1);
      if (iter_q == ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[IDX_W-1:0];

endmodule

// ----- sv/positional_circular_list_engine.sv -----
// Positional circular doubly linked list engine.
// Command port: a beat (action_i, position_i, data_in_i) is taken at a clock
// edge where start_i is high and busy_o is low. Actions: get, insert, remove
// at a list position; any other code reports the count and changes nothing.
// Result port: done_o is high for exactly one cycle and marks data_out_o,
// status_o (ok, list empty, store full) and count_o. The receiver cannot stall;
// the result must be taken in that cycle. One command is in flight at a time.
// Errors and the unused code answer in the cycle after the start. Insert at
// front, at end or into an empty list reads the free-chain head and then
// writes the links in S_WR1 and S_WR2. Remove and insert inside the list walk
// the links first, and get first runs a bit-serial remainder of position by
// count and then walks; steps is the number of links walked from the head (at
// most 255). The walk follows one link per cycle through the next-link memory
// read port.
// Reset: the list is empty and all 256 nodes sit on the free chain, held by
// per-entry valid bits on the link memory; no clearing pass is needed and the
// engine is idle and takes a command as soon as reset is released.
module positional_circular_list_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [plce_pkg::ACT_W-1:0]   action_i,
  input  logic [plce_pkg::POS_W-1:0]   position_i,
  input  logic [plce_pkg::DATA_W-1:0]  data_in_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [plce_pkg::DATA_W-1:0]  data_out_o,
  output logic [plce_pkg::STAT_W-1:0]  status_o,
  output logic [plce_pkg::CNT_W-1:0]   count_o
);
  import plce_pkg::*;

  state_e state_q, state_d;
  idx_t   head_q, head_d, tail_q, tail_d, free_q, free_d;
  idx_t   cur_q, cur_d, steps_q, steps_d, nd_q, nd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ACT_W-1:0]  op_q, op_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [DATA_W-1:0] din_q, din_d, dout_q, dout_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic              done_q, done_d;
  idx_t              wn_a_q [2], wn_a_d [2], wn_v_q [2], wn_v_d [2];
  idx_t              wp_a_q [2], wp_a_d [2], wp_v_q [2], wp_v_d [2];
  logic              wp_en_q, wp_en_d;

  logic [DATA_W-1:0] data_mem [DEPTH];
  idx_t              next_mem [DEPTH];
  idx_t              prev_mem [DEPTH];
  logic [DEPTH-1:0]  nvld_q;

  idx_t              rd_addr, rd_addr_q, next_raw_q, prev_rd_q, link;
  logic [DATA_W-1:0] data_rd_q;
  logic              nvld_rd_q;
  logic              n_we, p_we, d_we;
  idx_t              n_wa, n_wv, p_wa, p_wv;
  logic              div_start, div_done;
  idx_t              div_rem;
  logic              pos_zero, pos_ge_cnt, pos_ge_last;

  plce_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (position_i),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign link        = nvld_rd_q ? next_raw_q : rd_addr_q + idx_t'(1);
  assign pos_zero    = (pos_q == '0);
  assign pos_ge_cnt  = (pos_q >= POS_W'(cnt_q));
  assign pos_ge_last = (pos_q >= POS_W'(cnt_q - CNT_W'(1)));

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    free_d    = free_q;
    cur_d     = cur_q;
    steps_d   = steps_q;
    nd_d      = nd_q;
    cnt_d     = cnt_q;
    op_d      = op_q;
    pos_d     = pos_q;
    din_d     = din_q;
    dout_d    = dout_q;
    status_d  = status_q;
    done_d    = 1'b0;
    wn_a_d    = wn_a_q;
    wn_v_d    = wn_v_q;
    wp_a_d    = wp_a_q;
    wp_v_d    = wp_v_q;
    wp_en_d   = wp_en_q;
    div_start = 1'b0;
    rd_addr   = cur_q;
    d_we      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d     = action_i;
          pos_d    = position_i;
          din_d    = data_in_i;
          dout_d   = '0;
          status_d = ST_OK;
          case (action_i)
            ACT_GET: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
                done_d   = 1'b1;
              end else begin
                state_d = S_DIV;
              end
            end
            ACT_INSERT: begin
              if (cnt_q == CNT_FULL) begin
                status_d = ST_FULL;
                done_d   = 1'b1;
              end else begin
                state_d = S_INS_RD;
              end
            end
            ACT_REMOVE: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
                done_d   = 1'b1;
              end else begin
                steps_d = '0;
                if (cnt_q == CNT_W'(1) || position_i == '0) begin
                  cur_d = head_q;
                end else if (position_i >= POS_W'(cnt_q - CNT_W'(1))) begin
                  cur_d = tail_q;
                end else begin
                  cur_d   = head_q;
                  steps_d = position_i[IDX_W-1:0];
                end
                state_d = S_WALK;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          cur_d   = head_q;
          steps_d = div_rem;
          state_d = S_WALK;
        end
      end
      S_INS_RD: begin
        rd_addr = free_q;
        state_d = S_INS_FH;
      end
      S_INS_FH: begin
        nd_d   = free_q;
        free_d = link;
        d_we   = 1'b1;
        if (cnt_q == '0 || pos_zero || pos_ge_cnt) begin
          wp_en_d = 1'b1;
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = S_WR1;
          if (cnt_q == '0) begin
            wn_a_d = '{free_q, free_q};
            wn_v_d = '{free_q, free_q};
            wp_a_d = '{free_q, free_q};
            wp_v_d = '{free_q, free_q};
            head_d = free_q;
            tail_d = free_q;
          end else begin
            wn_a_d = '{tail_q, free_q};
            wn_v_d = '{free_q, head_q};
            wp_a_d = '{free_q, head_q};
            wp_v_d = '{tail_q, free_q};
            if (pos_ge_cnt) begin
              tail_d = free_q;
            end else begin
              head_d = free_q;
            end
          end
        end else begin
          cur_d   = head_q;
          steps_d = pos_q[IDX_W-1:0] - idx_t'(1);
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        state_d = S_STEP;
      end
      S_STEP: begin
        if (steps_q != '0) begin
          rd_addr = link;
          cur_d   = link;
          steps_d = steps_q - idx_t'(1);
        end else begin
          case (op_q)
            ACT_GET: begin
              dout_d  = data_rd_q;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
            ACT_INSERT: begin
              wn_a_d  = '{nd_q, cur_q};
              wn_v_d  = '{link, nd_q};
              wp_a_d  = '{link, nd_q};
              wp_v_d  = '{nd_q, cur_q};
              wp_en_d = 1'b1;
              cnt_d   = cnt_q + CNT_W'(1);
              state_d = S_WR1;
            end
            default: begin
              dout_d    = data_rd_q;
              wn_a_d[1] = cur_q;
              wn_v_d[1] = free_q;
              wp_en_d   = 1'b1;
              free_d    = cur_q;
              cnt_d     = cnt_q - CNT_W'(1);
              state_d   = S_WR1;
              if (cnt_q == CNT_W'(1)) begin
                wn_a_d[0] = cur_q;
                wn_v_d[0] = free_q;
                wp_en_d   = 1'b0;
                head_d    = '0;
                tail_d    = '0;
              end else if (pos_zero) begin
                head_d    = link;
                wn_a_d[0] = tail_q;
                wn_v_d[0] = link;
                wp_a_d    = '{link, link};
                wp_v_d    = '{tail_q, tail_q};
              end else if (pos_ge_last) begin
                tail_d    = prev_rd_q;
                wn_a_d[0] = prev_rd_q;
                wn_v_d[0] = head_q;
                wp_a_d    = '{head_q, head_q};
                wp_v_d    = '{prev_rd_q, prev_rd_q};
              end else begin
                wn_a_d[0] = prev_rd_q;
                wn_v_d[0] = link;
                wp_a_d    = '{link, link};
                wp_v_d    = '{prev_rd_q, prev_rd_q};
              end
            end
          endcase
        end
      end
      S_WR1: begin
        state_d = S_WR2;
      end
      S_WR2: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (state_q == S_IDLE && start_i && action_i == ACT_GET && cnt_q != '0) begin
      div_start = 1'b1;
    end
  end

  always_comb begin
    n_we = 1'b0;
    p_we = 1'b0;
    n_wa = wn_a_q[0];
    n_wv = wn_v_q[0];
    p_wa = wp_a_q[0];
    p_wv = wp_v_q[0];
    if (state_q == S_WR1) begin
      n_we = 1'b1;
      p_we = wp_en_q;
    end else if (state_q == S_WR2) begin
      n_we = 1'b1;
      p_we = wp_en_q;
      n_wa = wn_a_q[1];
      n_wv = wn_v_q[1];
      p_wa = wp_a_q[1];
      p_wv = wp_v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_we) begin
      data_mem[free_q] <= din_q;
    end
    if (n_we) begin
      next_mem[n_wa] <= n_wv;
    end
    if (p_we) begin
      prev_mem[p_wa] <= p_wv;
    end
    data_rd_q  <= data_mem[rd_addr];
    next_raw_q <= next_mem[rd_addr];
    prev_rd_q  <= prev_mem[rd_addr];
    rd_addr_q  <= rd_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nvld_q    <= '0;
      nvld_rd_q <= 1'b0;
    end else begin
      if (n_we) begin
        nvld_q[n_wa] <= 1'b1;
      end
      nvld_rd_q <= nvld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      free_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      wp_en_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      free_q  <= free_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      wp_en_q <= wp_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    steps_q  <= steps_d;
    nd_q     <= nd_d;
    op_q     <= op_d;
    pos_q    <= pos_d;
    din_q    <= din_d;
    dout_q   <= dout_d;
    status_q <= status_d;
    wn_a_q   <= wn_a_d;
    wn_v_q   <= wn_v_d;
    wp_a_q   <= wp_a_d;
    wp_v_q   <= wp_v_d;
  end

  assign busy_o     = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign data_out_o = dout_q;
  assign status_o   = status_q;
  assign count_o    = cnt_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result beat while busy");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL) else $error("count out of range");
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> count_o == CNT_FULL)
    else $error("full reported below capacity");
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> count_o == '0)
    else $error("empty reported on nonempty list");
  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !start_i) |=> $stable(cnt_q))
    else $error("count changed while idle");
`endif

endmodule

// ----- tb/positional_circular_list_engine_test.sv -----
module positional_circular_list_engine_test;
  timeunit 1ns;
  timeprecision 1ps;
  import plce_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
  } answer_t;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] data;
    bit                typed;
    answer_t           answer;
  } cmd_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [ACT_W-1:0] action_i = '0;
  logic [POS_W-1:0] position_i = '0;
  logic [DATA_W-1:0] data_in_i = '0;
  logic busy_o, done_o;
  logic [DATA_W-1:0] data_out_o;
  logic [STAT_W-1:0] status_o;
  logic [CNT_W-1:0] count_o;

  positional_circular_list_engine i_dut (.*);

  always #10 clk_i = ~clk_i;

  // list predictor state
  logic [DATA_W-1:0] word_mem [DEPTH];
  idx_t fwd_link [DEPTH];
  idx_t back_link [DEPTH];
  idx_t head_q, tail_q, free_q;
  int unsigned fill;

  answer_t expected_answers [$];
  int unsigned mismatches, checked, cycles;
  int unsigned inserts_seen, removes_seen, gets_seen, errors_seen;
  int send_gap_pct;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void list_clear();
    for (int i = 0; i < DEPTH; i++) fwd_link[i] = idx_t'((i + 1) % DEPTH);
    head_q = '0; tail_q = '0; free_q = '0; fill = 0;
  endfunction

  function automatic idx_t hop(input int unsigned steps);
    idx_t cur;
    cur = head_q;
    for (int unsigned i = 0; i < steps; i++) cur = fwd_link[cur];
    return cur;
  endfunction

  function automatic answer_t list_apply(input logic [ACT_W-1:0] act,
                                         input logic [POS_W-1:0] pos,
                                         input logic [DATA_W-1:0] din);
    answer_t r;
    idx_t nd, cur, nx, victim, p, n;
    r = '0;
    case (act)
      ACT_GET: begin
        if (fill == 0) r.status = ST_EMPTY;
        else r.data = word_mem[hop(pos % fill)];
      end
      ACT_INSERT: begin
        if (fill >= DEPTH) r.status = ST_FULL;
        else begin
          nd = free_q;
          free_q = fwd_link[nd];
          word_mem[nd] = din;
          if (fill == 0) begin
            fwd_link[nd] = nd; back_link[nd] = nd; head_q = nd; tail_q = nd;
          end else if (pos >= fill) begin
            fwd_link[tail_q] = nd; back_link[nd] = tail_q;
            fwd_link[nd] = head_q; back_link[head_q] = nd; tail_q = nd;
          end else if (pos == 0) begin
            fwd_link[nd] = head_q; back_link[head_q] = nd;
            back_link[nd] = tail_q; fwd_link[tail_q] = nd; head_q = nd;
          end else begin
            cur = hop(pos - 1);
            nx = fwd_link[cur];
            fwd_link[nd] = nx; back_link[nx] = nd;
            back_link[nd] = cur; fwd_link[cur] = nd;
          end
          fill++;
        end
      end
      ACT_REMOVE: begin
        if (fill == 0) r.status = ST_EMPTY;
        else begin
          if (fill == 1) begin
            victim = head_q; head_q = '0; tail_q = '0;
          end else if (pos == 0) begin
            victim = head_q;
            head_q = fwd_link[victim];
            back_link[head_q] = tail_q; fwd_link[tail_q] = head_q;
          end else if (pos >= fill - 1) begin
            victim = tail_q;
            tail_q = back_link[victim];
            fwd_link[tail_q] = head_q; back_link[head_q] = tail_q;
          end else begin
            victim = hop(pos);
            p = back_link[victim]; n = fwd_link[victim];
            fwd_link[p] = n; back_link[n] = p;
          end
          r.data = word_mem[victim];
          fwd_link[victim] = free_q;
          free_q = victim;
          fill--;
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(fill);
    return r;
  endfunction

  // start_i stays high across beats unless the sender idles; a beat is taken
  // at the first rising edge with busy_o low, sampled mid-cycle
  task automatic issue(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                       input logic [DATA_W-1:0] din, input bit typed, input answer_t want);
    answer_t predicted;
    logic    idle_seen;
    while ($urandom_range(99) < send_gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    predicted = list_apply(act, pos, din);
    if (typed && predicted != want) report("directed row vs predictor", predicted, want);
    expected_answers.push_back(predicted);
    case (act)
      ACT_GET: gets_seen++;
      ACT_INSERT: inserts_seen++;
      ACT_REMOVE: removes_seen++;
      default: ;
    endcase
    if (predicted.status != ST_OK) errors_seen++;
    start_i <= 1'b1;
    action_i <= act;
    position_i <= pos;
    data_in_i <= din;
    do begin
      @(negedge clk_i);
      idle_seen = !busy_o;
      @(posedge clk_i);
    end while (!idle_seen);
  endtask

  always @(negedge clk_i) begin
    answer_t want;
    if (rst_ni && done_o) begin
      if (expected_answers.size() == 0) report("unexpected beat", done_o, 0);
      else begin
        want = expected_answers.pop_front();
        checked++;
        if (data_out_o !== want.data) report("data_out", data_out_o, want.data);
        if (status_o !== want.status) report("status", status_o, want.status);
        if (count_o !== want.count) report("count", count_o, want.count);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(5))
      0: return '0;
      1: return POS_W'(fill);
      2: return POS_W'(fill == 0 ? 0 : fill - 1);
      3: return POS_W'($urandom);
      default: return POS_W'($urandom_range(fill + 1));
    endcase
  endfunction

  task automatic random_phase(input int n, input int ins_bias);
    logic [ACT_W-1:0] act;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 3) act = ACT_NOP;
      else if (r < ins_bias) act = ACT_INSERT;
      else if (r < ins_bias + 25) act = ACT_GET;
      else act = ACT_REMOVE;
      issue(act, pick_pos(), $urandom, 1'b0, '0);
    end
  endtask

  cmd_row_t rows [$];

  initial begin
    answer_t none;
    none = '0;
    list_clear();
    send_gap_pct = 0;
    rows = '{
      '{ACT_GET,    16'd0,     32'h0,        1, '{32'h0, ST_EMPTY, 9'd0}},
      '{ACT_REMOVE, 16'hFFFF,  32'h0,        1, '{32'h0, ST_EMPTY, 9'd0}},
      '{ACT_NOP,    16'h1234,  32'hFFFF_FFFF, 1, '{32'h0, ST_OK, 9'd0}},
      '{ACT_INSERT, 16'hFFFF,  32'hFFFF_FFFF, 1, '{32'h0, ST_OK, 9'd1}},
      '{ACT_GET,    16'hFFFF,  32'h0,        1, '{32'hFFFF_FFFF, ST_OK, 9'd1}},
      '{ACT_REMOVE, 16'd0,     32'h0,        1, '{32'hFFFF_FFFF, ST_OK, 9'd0}},
      '{ACT_INSERT, 16'd0,     32'h0000_0001, 0, none},
      '{ACT_INSERT, 16'd0,     32'h8000_0000, 0, none},
      '{ACT_INSERT, 16'd5,     32'hA5A5_5A5A, 0, none},
      '{ACT_INSERT, 16'd1,     32'h0000_0000, 0, none},
      '{ACT_INSERT, 16'd2,     32'h5A5A_A5A5, 0, none},
      '{ACT_GET,    16'd0,     32'h0,        0, none},
      '{ACT_GET,    16'd7,     32'h0,        0, none},
      '{ACT_GET,    16'hFFFF,  32'h0,        0, none},
      '{ACT_REMOVE, 16'd2,     32'h0,        0, none},
      '{ACT_REMOVE, 16'd0,     32'h0,        0, none},
      '{ACT_REMOVE, 16'hFFFF,  32'h0,        0, none},
      '{ACT_REMOVE, 16'd1,     32'h0,        0, none},
      '{ACT_REMOVE, 16'd0,     32'h0,        0, none},
      '{ACT_REMOVE, 16'd0,     32'h0,        1, '{32'h0, ST_EMPTY, 9'd0}},
      '{ACT_NOP,    16'd0,     32'h0,        1, '{32'h0, ST_OK, 9'd0}}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[k]) issue(rows[k].action, rows[k].position, rows[k].data,
                            rows[k].typed, rows[k].answer);
    // fill to the top, hit store full, then drain
    for (int i = 0; i < DEPTH; i++)
      issue(ACT_INSERT, POS_W'($urandom_range(i)), $urandom, 1'b0, none);
    issue(ACT_INSERT, 16'd0, 32'hDEAD_BEEF, 1'b1, '{32'h0, ST_FULL, 9'(DEPTH)});
    issue(ACT_GET, 16'hFFFF, 32'h0, 1'b0, none);
    for (int i = 0; i < DEPTH; i++)
      issue(ACT_REMOVE, pick_pos(), 32'h0, 1'b0, none);
    send_gap_pct = 7;
    random_phase(200, 55);
    send_gap_pct = 65;
    random_phase(100, 40);
    send_gap_pct = 0;
    random_phase(170, 50);
    start_i <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("covered %0d inserts, %0d removes, %0d gets, %0d empty/full errors",
             inserts_seen, removes_seen, gets_seen, errors_seen);
    $display("%0d results checked, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
sv/plce_pkg.sv
sv/plce_div.sv
sv/positional_circular_list_engine.sv
tb/positional_circular_list_engine_test.sv
